/* rtl/binary_trie_max_xor_defines.svh */
// ----------------------------------------------------------------------------
// Binary trie max-XOR assertion macros
// Property wrappers used by the top-level block to check its behavior.
// ----------------------------------------------------------------------------
`ifndef BINARY_TRIE_MAX_XOR_DEFINES_SVH
`define BINARY_TRIE_MAX_XOR_DEFINES_SVH

// Same-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define BTMX_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on i_clk and disabled while i_rst_n is low.
`define BTMX_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/btmx_pkg.sv */
// ----------------------------------------------------------------------------
// Binary trie max-XOR package
// Field widths, codes and the command and status types shared by the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package btmx_pkg;

    localparam int OPCODE_W = 2;
    localparam int KEY_W    = 32;
    localparam int STATUS_W = 2;
    localparam int USES_W   = 20;

    localparam int KEY_BITS_DEF   = 32;
    localparam int POOL_NODES_DEF = 4096;

    localparam logic [USES_W-1:0] USES_MAX = '1;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_QUERY  = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_ABSENT = 2'd1,
        ST_FULL   = 2'd2,
        ST_EMPTY  = 2'd3
    } t_status;

    // Datapath commands issued by the controller, one per cycle.
    typedef enum logic [3:0] {
        DP_NOP,
        DP_INIT,
        DP_LOAD,
        DP_RESTART,
        DP_CHECK_STEP,
        DP_WRITE_STEP,
        DP_Q_PROBE,
        DP_Q_TAKE,
        DP_Q_SAME_NOW,
        DP_Q_SAME_SAVED,
        DP_FINISH
    } t_dp_op;

    typedef struct packed {
        t_dp_op  op;
        t_status status;
    } t_dp_cmd;

    typedef struct packed {
        t_opcode op;
        logic    uses_zero;
        logic    uses_full;
        logic    roomy;
        logic    child_zero;
        logic    opp_zero;
        logic    same_saved_zero;
        logic    need_fits;
        logic    bit_zero;
        logic    leaf;
        logic    out_busy;
    } t_dp_stat;

endpackage

`default_nettype wire

/* rtl/btmx_if.sv */
// ----------------------------------------------------------------------------
// Binary trie max-XOR channels
// Valid/ready channels for the request items and the result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface btmx_item_if;
    logic                           valid;
    logic                           ready;
    logic [btmx_pkg::OPCODE_W-1:0]  opcode;
    logic [btmx_pkg::KEY_W-1:0]     key;

    modport source (output valid, output opcode, output key, input ready);
    modport sink   (input valid, input opcode, input key, output ready);
endinterface

interface btmx_result_if;
    logic                           valid;
    logic                           ready;
    logic [btmx_pkg::STATUS_W-1:0]  status;
    logic [btmx_pkg::KEY_W-1:0]     max_xor;

    modport source (output valid, output status, output max_xor, input ready);
    modport sink   (input valid, input status, input max_xor, output ready);
endinterface

`default_nettype wire

/* rtl/btmx_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered, enable-held read data.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/btmx_datapath.sv */
// ----------------------------------------------------------------------------
// Binary trie max-XOR datapath
// Node pool, walk registers, allocation pointer and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_datapath #(
    parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF,
    parameter int POOL_NODES = btmx_pkg::POOL_NODES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire btmx_pkg::t_dp_cmd             i_cmd,
    output btmx_pkg::t_dp_stat                 o_stat,
    input  wire logic [btmx_pkg::OPCODE_W-1:0] i_opcode,
    input  wire logic [btmx_pkg::KEY_W-1:0]    i_key,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [btmx_pkg::STATUS_W-1:0]      o_status,
    output logic [btmx_pkg::KEY_W-1:0]         o_max_xor
);

    localparam int LINK_W = $clog2(POOL_NODES);
    localparam int NF_W   = LINK_W + 1;
    localparam int BIT_W  = $clog2(KEY_BITS);
    localparam int USES_W = btmx_pkg::USES_W;
    localparam int REC_W  = 2 * LINK_W + USES_W;
    localparam int KW     = btmx_pkg::KEY_W;

    typedef struct packed {
        logic [LINK_W-1:0] zero_child;
        logic [LINK_W-1:0] one_child;
        logic [USES_W-1:0] uses;
    } t_node;

    btmx_pkg::t_opcode        r_op, n_op;
    logic [KEY_BITS-1:0]      r_key, n_key;
    logic [BIT_W-1:0]         r_bit, n_bit;
    logic [LINK_W-1:0]        r_node, n_node;
    logic                     r_leaf, n_leaf;
    logic                     r_fresh, n_fresh;
    logic [KEY_BITS-1:0]      r_acc, n_acc;
    logic [LINK_W-1:0]        r_same, n_same;
    logic [NF_W-1:0]          r_next_free, n_next_free;
    logic                     r_out_valid, n_out_valid;
    btmx_pkg::t_status        r_out_status, n_out_status;
    logic [KW-1:0]            r_out_xor, n_out_xor;

    logic                     w_we;
    logic [LINK_W-1:0]        w_waddr;
    logic [REC_W-1:0]         w_wdata;
    logic                     w_re;
    logic [LINK_W-1:0]        w_raddr;
    logic [REC_W-1:0]         w_rdata;

    t_node                    w_rec;
    t_node                    w_base;
    t_node                    w_wrec;
    logic                     w_bit;
    logic [LINK_W-1:0]        w_child;
    logic [LINK_W-1:0]        w_opp;
    logic [LINK_W-1:0]        w_base_child;
    logic                     w_alloc;
    logic [LINK_W-1:0]        w_new_link;
    logic [NF_W-1:0]          w_free_left;
    logic [NF_W-1:0]          w_need;
    logic                     w_adv;

    btmx_ram #(
        .WIDTH (REC_W),
        .DEPTH (POOL_NODES)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rec = t_node'(w_rdata);

    // Node record arithmetic for the current level.
    always_comb begin
        w_bit        = r_key[r_bit];
        w_child      = w_bit ? w_rec.one_child : w_rec.zero_child;
        w_opp        = w_bit ? w_rec.zero_child : w_rec.one_child;
        // A node allocated in this pass has not been read; it starts empty.
        w_base       = r_fresh ? t_node'('0) : w_rec;
        w_base_child = w_bit ? w_base.one_child : w_base.zero_child;
        w_alloc      = (w_base_child == '0) && !r_leaf;
        w_new_link   = w_alloc ? r_next_free[LINK_W-1:0] : w_base_child;
        w_wrec       = w_base;
        if (r_op == btmx_pkg::OP_INSERT) begin
            w_wrec.uses = w_base.uses + USES_W'(1);
        end else begin
            w_wrec.uses = w_base.uses - USES_W'(1);
        end
        if (!r_leaf) begin
            if (w_bit) begin
                w_wrec.one_child = w_new_link;
            end else begin
                w_wrec.zero_child = w_new_link;
            end
        end
        w_free_left = NF_W'(POOL_NODES) - r_next_free;
        w_need      = NF_W'(r_bit) + NF_W'(1);
    end

    always_comb begin
        o_stat.op              = r_op;
        o_stat.uses_zero       = (w_rec.uses == '0);
        o_stat.uses_full       = (w_rec.uses >= btmx_pkg::USES_MAX);
        o_stat.roomy           = (w_free_left >= NF_W'(KEY_BITS));
        o_stat.child_zero      = (w_child == '0);
        o_stat.opp_zero        = (w_opp == '0);
        o_stat.same_saved_zero = (r_same == '0);
        o_stat.need_fits       = (w_need <= w_free_left);
        o_stat.bit_zero        = (r_bit == '0);
        o_stat.leaf            = r_leaf;
        o_stat.out_busy        = r_out_valid && !i_out_ready;
    end

    // Command decode.
    always_comb begin
        n_op         = r_op;
        n_key        = r_key;
        n_bit        = r_bit;
        n_node       = r_node;
        n_leaf       = r_leaf;
        n_fresh      = r_fresh;
        n_acc        = r_acc;
        n_same       = r_same;
        n_next_free  = r_next_free;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_xor    = r_out_xor;
        w_we         = 1'b0;
        w_waddr      = r_node;
        w_wdata      = REC_W'(w_wrec);
        w_re         = 1'b0;
        w_raddr      = w_child;
        w_adv        = 1'b0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (i_cmd.op)
            btmx_pkg::DP_NOP: begin
            end
            btmx_pkg::DP_INIT: begin
                w_we    = 1'b1;
                w_waddr = '0;
                w_wdata = '0;
            end
            btmx_pkg::DP_LOAD: begin
                n_op    = btmx_pkg::t_opcode'(i_opcode);
                n_key   = KEY_BITS'(i_key);
                n_bit   = BIT_W'(KEY_BITS - 1);
                n_node  = '0;
                n_leaf  = 1'b0;
                n_fresh = 1'b0;
                n_acc   = '0;
                w_re    = 1'b1;
                w_raddr = '0;
            end
            btmx_pkg::DP_RESTART: begin
                n_bit   = BIT_W'(KEY_BITS - 1);
                n_node  = '0;
                n_leaf  = 1'b0;
                n_fresh = 1'b0;
                w_re    = 1'b1;
                w_raddr = '0;
            end
            btmx_pkg::DP_CHECK_STEP: begin
                w_re    = 1'b1;
                w_raddr = w_child;
                n_node  = w_child;
                w_adv   = 1'b1;
            end
            btmx_pkg::DP_WRITE_STEP: begin
                w_we = 1'b1;
                if (!r_leaf) begin
                    n_node  = w_new_link;
                    n_fresh = w_alloc;
                    if (w_alloc) begin
                        n_next_free = r_next_free + NF_W'(1);
                    end
                    w_re    = !w_alloc;
                    w_raddr = w_new_link;
                    w_adv   = 1'b1;
                end
            end
            btmx_pkg::DP_Q_PROBE: begin
                w_re    = 1'b1;
                w_raddr = w_opp;
                n_same  = w_child;
            end
            btmx_pkg::DP_Q_TAKE: begin
                n_acc[r_bit] = 1'b1;
                w_adv        = 1'b1;
            end
            btmx_pkg::DP_Q_SAME_NOW: begin
                w_re    = 1'b1;
                w_raddr = w_child;
                w_adv   = 1'b1;
            end
            btmx_pkg::DP_Q_SAME_SAVED: begin
                w_re    = 1'b1;
                w_raddr = r_same;
                w_adv   = 1'b1;
            end
            btmx_pkg::DP_FINISH: begin
                n_out_valid  = 1'b1;
                n_out_status = i_cmd.status;
                n_out_xor    = KW'(r_acc);
            end
            default: begin
            end
        endcase

        // Step down one level; past bit zero the walk sits on the leaf.
        if (w_adv) begin
            if (r_bit == '0) begin
                n_leaf = 1'b1;
            end else begin
                n_bit = r_bit - BIT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_free <= NF_W'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_next_free <= n_next_free;
            r_out_valid <= n_out_valid;
        end
        r_op         <= n_op;
        r_key        <= n_key;
        r_bit        <= n_bit;
        r_node       <= n_node;
        r_leaf       <= n_leaf;
        r_fresh      <= n_fresh;
        r_acc        <= n_acc;
        r_same       <= n_same;
        r_out_status <= n_out_status;
        r_out_xor    <= n_out_xor;
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_max_xor   = r_out_xor;

endmodule

`default_nettype wire

/* rtl/btmx_ctrl.sv */
// ----------------------------------------------------------------------------
// Binary trie max-XOR controller
// Sequences the check, update and query walks over the node pool.
// ----------------------------------------------------------------------------
`default_nettype none

module btmx_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire btmx_pkg::t_dp_stat   i_stat,
    output btmx_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_START,
        S_CHECK,
        S_LEAF,
        S_WRITE,
        S_QUERY,
        S_PROBE,
        S_DONE
    } t_state;

    t_state            r_state, n_state;
    btmx_pkg::t_status r_status, n_status;

    always_comb begin
        n_state      = r_state;
        n_status     = r_status;
        o_cmd.op     = btmx_pkg::DP_NOP;
        o_cmd.status = r_status;
        o_in_ready   = 1'b0;

        unique case (r_state)
            S_INIT: begin
                // Clear the root entry; all other nodes are written on allocation.
                o_cmd.op = btmx_pkg::DP_INIT;
                n_state  = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = btmx_pkg::DP_LOAD;
                    n_status = btmx_pkg::ST_OK;
                    n_state  = S_START;
                end
            end
            S_START: begin
                unique case (i_stat.op)
                    btmx_pkg::OP_INSERT: begin
                        if (i_stat.uses_full) begin
                            n_status = btmx_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end else if (i_stat.roomy) begin
                            n_state = S_WRITE;
                        end else begin
                            n_state = S_CHECK;
                        end
                    end
                    btmx_pkg::OP_DELETE: begin
                        n_state = S_CHECK;
                    end
                    btmx_pkg::OP_QUERY: begin
                        if (i_stat.uses_zero) begin
                            n_status = btmx_pkg::ST_EMPTY;
                            n_state  = S_DONE;
                        end else begin
                            n_state = S_QUERY;
                        end
                    end
                    default: begin
                        n_state = S_DONE;
                    end
                endcase
            end
            S_CHECK: begin
                if (i_stat.child_zero) begin
                    if (i_stat.op == btmx_pkg::OP_INSERT) begin
                        if (i_stat.need_fits) begin
                            o_cmd.op = btmx_pkg::DP_RESTART;
                            n_state  = S_WRITE;
                        end else begin
                            n_status = btmx_pkg::ST_FULL;
                            n_state  = S_DONE;
                        end
                    end else begin
                        n_status = btmx_pkg::ST_ABSENT;
                        n_state  = S_DONE;
                    end
                end else if (i_stat.op == btmx_pkg::OP_INSERT && i_stat.bit_zero) begin
                    o_cmd.op = btmx_pkg::DP_RESTART;
                    n_state  = S_WRITE;
                end else begin
                    o_cmd.op = btmx_pkg::DP_CHECK_STEP;
                    if (i_stat.bit_zero) begin
                        n_state = S_LEAF;
                    end
                end
            end
            S_LEAF: begin
                // A path whose leaf count has dropped to zero holds no copy.
                if (i_stat.uses_zero) begin
                    n_status = btmx_pkg::ST_ABSENT;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = btmx_pkg::DP_RESTART;
                    n_state  = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.op = btmx_pkg::DP_WRITE_STEP;
                if (i_stat.leaf) begin
                    n_state = S_DONE;
                end
            end
            S_QUERY: begin
                if (!i_stat.opp_zero) begin
                    o_cmd.op = btmx_pkg::DP_Q_PROBE;
                    n_state  = S_PROBE;
                end else if (i_stat.child_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = btmx_pkg::DP_Q_SAME_NOW;
                    if (i_stat.bit_zero) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_PROBE: begin
                // The probed node stays in the read register when it is taken.
                if (!i_stat.uses_zero) begin
                    o_cmd.op = btmx_pkg::DP_Q_TAKE;
                    n_state  = i_stat.bit_zero ? S_DONE : S_QUERY;
                end else if (i_stat.same_saved_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.op = btmx_pkg::DP_Q_SAME_SAVED;
                    n_state  = i_stat.bit_zero ? S_DONE : S_QUERY;
                end
            end
            S_DONE: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = btmx_pkg::DP_FINISH;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_status <= btmx_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_status <= n_status;
        end
    end

endmodule

`default_nettype wire

/* rtl/binary_trie_max_xor.sv */
// ----------------------------------------------------------------------------
// Binary trie max-XOR block
// Multiset of keys in a binary trie with insert, delete and max-XOR query.
// ----------------------------------------------------------------------------
// Requests arrive on i_item (opcode, key) and each one produces exactly one
// item on o_result (status, max_xor); both channels use valid/ready.
// One request is worked on at a time, so a new request is not taken before
// the last one is through. An insert walks the path and writes one node per
// level; when fewer than KEY_BITS free nodes remain, the path is checked
// first. A delete checks the path down to the leaf before it writes, and
// stops early when it misses its key. A query makes one or two node reads
// per key bit. An unused opcode, an insert at a full root count and a query
// on an empty set go straight to the result. The node memory has a single
// read port, with one access per trie level. The result becomes valid in the
// same cycle in which the next request can be accepted. After reset the
// S_INIT state clears the root node; i_item.ready rises after that. A
// stalled result sits in the output register; the current request finishes
// and waits there until the register is free.
// ----------------------------------------------------------------------------
`default_nettype none

`include "binary_trie_max_xor_defines.svh"

module binary_trie_max_xor #(
    parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF,
    parameter int POOL_NODES = btmx_pkg::POOL_NODES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    btmx_item_if.sink   i_item,
    btmx_result_if.source o_result
);

    btmx_pkg::t_dp_cmd  w_cmd;
    btmx_pkg::t_dp_stat w_stat;
    logic               w_in_ready;

    btmx_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    btmx_datapath #(
        .KEY_BITS   (KEY_BITS),
        .POOL_NODES (POOL_NODES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_opcode    (i_item.opcode),
        .i_key       (i_item.key),
        .o_out_valid (o_result.valid),
        .i_out_ready (o_result.ready),
        .o_status    (o_result.status),
        .o_max_xor   (o_result.max_xor)
    );

    assign i_item.ready = w_in_ready;

    `BTMX_ASSERT_IMP(a_fail_zero_xor, o_result.valid && (o_result.status != btmx_pkg::ST_OK), o_result.max_xor == '0, "failed request carries a nonzero max_xor")
    `BTMX_ASSERT_NXT(a_one_at_a_time, i_item.valid && i_item.ready, !i_item.ready, "new request accepted while one is in progress")
    `BTMX_ASSERT_IMP(a_finish_slot_free, w_cmd.op == btmx_pkg::DP_FINISH, !w_stat.out_busy, "result written into an occupied output register")

endmodule

`default_nettype wire
